@@ hw/rtl/two_way_lru_writeback_cache_defines.svh @@
// assertion macros for the two-way cache
`ifndef TWO_WAY_LRU_WRITEBACK_CACHE_DEFINES_SVH
`define TWO_WAY_LRU_WRITEBACK_CACHE_DEFINES_SVH

// condition implies consequence in the same cycle
`define TWLC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("twlc same-cycle check failed");

// condition implies consequence in the next cycle
`define TWLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("twlc next-cycle check failed");

`endif

@@ hw/rtl/twlc_pkg.sv @@
package twlc_pkg;

   localparam int SET_COUNT  = 8;
   localparam int MEM_WORDS  = 128;
   localparam int REG_COUNT  = 8;
   localparam int WAY_COUNT  = 2;
   localparam int DATA_W     = 32;
   localparam int OFFSET_W   = 9;
   localparam int SEL_W      = 3;
   localparam int SET_BITS   = $clog2(SET_COUNT);
   localparam int WORD_BITS  = $clog2(MEM_WORDS);
   localparam int TAG_BITS   = WORD_BITS - SET_BITS;
   localparam int REG_BITS   = $clog2(REG_COUNT);
   localparam int MEM_BASE   = 5;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_STORE = 1'b1;

   typedef struct packed {
      logic                func;
      logic [OFFSET_W-1:0] byte_offset;
      logic [SEL_W-1:0]    reg_sel;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic                     wrote_back;
      logic signed [DATA_W-1:0] load_value;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic mem_read;
      logic commit_lookup;
      logic commit_fill;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic is_store;
   } sts_type;

endpackage

@@ hw/rtl/twlc_dp.sv @@
`include "two_way_lru_writeback_cache_defines.svh"

module twlc_dp (
   input  logic              clock,
   input  logic              reset,
   input  twlc_pkg::cmd_type cmd,
   input  twlc_pkg::req_type req_data,
   output twlc_pkg::sts_type sts,
   output twlc_pkg::rsp_type rsp_data
);

   logic                             func_ff;
   logic [twlc_pkg::WORD_BITS-1:0]   word_ff;
   logic [twlc_pkg::REG_BITS-1:0]    reg_ff;

   logic [1:0]                       valid_ff  [twlc_pkg::SET_COUNT];
   logic [1:0]                       recent_ff [twlc_pkg::SET_COUNT];
   logic [twlc_pkg::TAG_BITS-1:0]    tag_ff    [twlc_pkg::SET_COUNT][twlc_pkg::WAY_COUNT];
   logic [twlc_pkg::DATA_W-1:0]      data_ff   [twlc_pkg::SET_COUNT][twlc_pkg::WAY_COUNT];
   logic [twlc_pkg::DATA_W-1:0]      regs_ff   [twlc_pkg::REG_COUNT];

   logic [twlc_pkg::DATA_W-1:0]      mem_ff    [twlc_pkg::MEM_WORDS];
   logic [twlc_pkg::MEM_WORDS-1:0]   mem_init_ff;
   logic [twlc_pkg::DATA_W-1:0]      rd_word_ff;
   logic                             rd_init_ff;
   logic [twlc_pkg::WORD_BITS-1:0]   rd_addr_ff;

   twlc_pkg::rsp_type                rsp_ff;
   twlc_pkg::rsp_type                rsp_in;

   logic [twlc_pkg::SET_BITS-1:0]    set_w;
   logic [twlc_pkg::TAG_BITS-1:0]    tag_w;
   logic                             is_store;
   logic                             hit0;
   logic                             hit1;
   logic                             hit_w;
   logic                             hit_way;
   logic [1:0]                       hit_ways;
   logic                             victim_way;
   logic                             victim_valid;
   logic [twlc_pkg::DATA_W-1:0]      reg_word;
   logic [twlc_pkg::DATA_W-1:0]      hit_word;
   logic [twlc_pkg::DATA_W-1:0]      fill_word;
   logic                             mem_wr_en;
   logic [twlc_pkg::WORD_BITS-1:0]   mem_wr_addr;
   logic [twlc_pkg::DATA_W-1:0]      mem_wr_data;
   logic [1:0]                       hit_mark;
   logic [1:0]                       fill_mark;
   logic                             hit_commit;

   // word address wraps to memory size, set is its low bits
   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff <= twlc_pkg::FUNC_LOAD;
         word_ff <= '0;
         reg_ff  <= '0;
      end else if (cmd.capture) begin
         func_ff <= req_data.func;
         word_ff <= twlc_pkg::WORD_BITS'(req_data.byte_offset >> 2);
         reg_ff  <= twlc_pkg::REG_BITS'(req_data.reg_sel);
      end
   end

   always_comb begin
      set_w        = word_ff[twlc_pkg::SET_BITS-1:0];
      tag_w        = word_ff[twlc_pkg::WORD_BITS-1:twlc_pkg::SET_BITS];
      is_store     = (func_ff == twlc_pkg::FUNC_STORE);
      hit0         = valid_ff[set_w][0] && (tag_ff[set_w][0] == tag_w);
      hit1         = valid_ff[set_w][1] && (tag_ff[set_w][1] == tag_w);
      hit_w        = hit0 || hit1;
      hit_way      = !hit0;
      hit_ways     = {hit1, hit0};
      victim_way   = recent_ff[set_w][0];
      victim_valid = valid_ff[set_w][victim_way];
      reg_word     = regs_ff[reg_ff];
      hit_word     = data_ff[set_w][hit_way];
      fill_word    = rd_init_ff ? rd_word_ff
                               : twlc_pkg::DATA_W'(twlc_pkg::MEM_BASE) +
                                 twlc_pkg::DATA_W'(rd_addr_ff);
      hit_mark     = hit_way ? 2'b10 : 2'b01;
      fill_mark    = victim_way ? 2'b10 : 2'b01;
      hit_commit   = cmd.commit_lookup && hit_w;
      mem_wr_en    = cmd.commit_lookup && !hit_w && (is_store || victim_valid);
      mem_wr_addr  = is_store ? word_ff : {tag_ff[set_w][victim_way], set_w};
      mem_wr_data  = is_store ? reg_word : data_ff[set_w][victim_way];
   end

   // main memory, untouched words read as base plus address
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem_ff[mem_wr_addr] <= mem_wr_data;
      end
      if (cmd.mem_read) begin
         rd_word_ff <= mem_ff[word_ff];
         rd_init_ff <= mem_init_ff[word_ff];
         rd_addr_ff <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_init_ff <= '0;
      end else if (mem_wr_en) begin
         mem_init_ff[mem_wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < twlc_pkg::SET_COUNT; s++) begin
            valid_ff[s]  <= 2'b00;
            recent_ff[s] <= 2'b00;
         end
         for (int r = 0; r < twlc_pkg::REG_COUNT; r++) begin
            regs_ff[r] <= '0;
         end
      end else begin
         if (hit_commit) begin
            recent_ff[set_w] <= hit_mark;
            if (!is_store) begin
               regs_ff[reg_ff] <= hit_word;
            end
         end
         if (cmd.commit_fill) begin
            valid_ff[set_w][victim_way] <= 1'b1;
            recent_ff[set_w]            <= fill_mark;
            regs_ff[reg_ff]             <= fill_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit_commit && is_store) begin
         data_ff[set_w][hit_way] <= reg_word;
      end
      if (cmd.commit_fill) begin
         tag_ff[set_w][victim_way]  <= tag_w;
         data_ff[set_w][victim_way] <= fill_word;
      end
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.commit_lookup && (hit_w || is_store)) begin
         rsp_in.hit        = hit_w;
         rsp_in.wrote_back = 1'b0;
         rsp_in.load_value = (hit_w && !is_store) ? $signed(hit_word) : '0;
      end else if (cmd.commit_fill) begin
         rsp_in.hit        = 1'b0;
         rsp_in.wrote_back = victim_valid;
         rsp_in.load_value = $signed(fill_word);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign sts.hit      = hit_w;
   assign sts.is_store = is_store;
   assign rsp_data     = rsp_ff;

   `TWLC_ASSERT_SAME(a_single_way_hit, 1'b1, $onehot0(hit_ways))
   `TWLC_ASSERT_SAME(a_single_recent, 1'b1, $onehot0(recent_ff[set_w]))
   `TWLC_ASSERT_SAME(a_fill_on_miss, cmd.commit_fill, !hit_w && !is_store)

endmodule

@@ hw/rtl/twlc_ctrl.sv @@
`include "two_way_lru_writeback_cache_defines.svh"

module twlc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  twlc_pkg::sts_type sts,
   output twlc_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_FILL   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;
   logic      produce;

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      state_in  = state_ff;
      cmd       = '0;
      produce   = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.mem_read = 1'b1;
            if (sts.hit || sts.is_store) begin
               if (slot_free) begin
                  cmd.commit_lookup = 1'b1;
                  produce           = 1'b1;
                  state_in          = ST_IDLE;
               end
            end else begin
               // load miss: write back a valid victim, then fill once the response register is free
               cmd.commit_lookup = 1'b1;
               state_in          = ST_FILL;
            end
         end
         ST_FILL: begin
            if (slot_free) begin
               cmd.commit_fill = 1'b1;
               produce         = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = produce || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TWLC_ASSERT_NEXT(a_fill_then_idle, state_ff == ST_FILL, state_ff != ST_LOOKUP)
   `TWLC_ASSERT_SAME(a_fill_only_load_miss, (state_ff == ST_LOOKUP) && (state_in == ST_FILL), !sts.hit && !sts.is_store)
   `TWLC_ASSERT_NEXT(a_transfer_starts_lookup, req_valid && req_ready, state_ff == ST_LOOKUP)

endmodule

@@ hw/rtl/two_way_lru_writeback_cache.sv @@
// Two-way set-associative write-back cache (8 sets, one word a line, LRU by a
// most-recent mark) in front of a 128-word main memory and an 8-entry register
// file. Each request transfer is a load or a store; each yields one response.
// The response is registered: a hit or a store yields it from the lookup state,
// a load miss from the fill state. The main memory has one write port and a
// registered read, so a load miss writes back a valid victim and reads the
// fill word in the lookup state and installs the line in the fill state. One
// request is in work at a time; a new request is taken as soon as the previous
// response is registered, while that response still waits on rsp_ready, and a
// hit, a store or a fill then waits until the response register is free.
// Untouched memory words read as five plus their word address, with no clearing
// pass after reset.
module two_way_lru_writeback_cache (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  twlc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output twlc_pkg::rsp_type rsp_data
);

   twlc_pkg::cmd_type cmd;
   twlc_pkg::sts_type sts;

   twlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   twlc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
